// ----- src/lpfr_pkg.sv -----
// Shared types and constants for the LRU page-frame replacer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpfr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  // Width of one recency-order entry and of the frames_in_use register.
  localparam int ORDER_W     = 4;
  localparam int CFG_W       = 4;
  localparam int FRAME_IDX_W = 3;

  localparam logic [ORDER_W-1:0] EMPTY_CODE   = 4'hF;
  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POS,
    ST_VICTIM,
    ST_EVICT,
    ST_SHIFT,
    ST_RESULT
  } lpfr_state_e;

  typedef struct packed {
    logic clear;
    logic page_we;
    logic order_we;
  } lpfr_store_cmd_t;

endpackage

`default_nettype wire

// ----- src/lpfr_store.sv -----
// Frame table and recency order of the LRU page-frame replacer.
// Depends on lpfr_pkg; instantiated by lru_page_frame_replacer.
`default_nettype none

module lpfr_store
  import lpfr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  localparam int IdxW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  lpfr_store_cmd_t        cmd_i,
  input  wire  [IdxW-1:0]        page_raddr_i,
  input  wire  [IdxW-1:0]        page_waddr_i,
  input  wire  [PAGE_BITS-1:0]   page_wdata_i,
  output logic [PAGE_BITS-1:0]   page_rdata_o,
  input  wire  [IdxW-1:0]        order_raddr_i,
  input  wire  [IdxW-1:0]        order_waddr_i,
  input  wire  [ORDER_W-1:0]     order_wdata_i,
  output logic [ORDER_W-1:0]     order_rdata_o
);

  logic [PAGE_BITS-1:0] page_q  [MAX_FRAMES];
  logic [ORDER_W-1:0]   order_q [MAX_FRAMES];

  // A configuration write empties every frame at once, just like reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        page_q[i]  <= '0;
        order_q[i] <= EMPTY_CODE;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        page_q[i]  <= '0;
        order_q[i] <= EMPTY_CODE;
      end
    end else begin
      if (cmd_i.page_we) begin
        page_q[page_waddr_i] <= page_wdata_i;
      end
      if (cmd_i.order_we) begin
        order_q[order_waddr_i] <= order_wdata_i;
      end
    end
  end

  assign page_rdata_o  = page_q[page_raddr_i];
  assign order_rdata_o = order_q[order_raddr_i];

endmodule

`default_nettype wire

// ----- src/lru_page_frame_replacer.sv -----
// Top level of the LRU page-frame replacer: request sequencer and result register.
// Depends on lpfr_pkg and lpfr_store.
`default_nettype none

// Each request carries one page number and produces one result: hit, the frame
// that now holds the page, and the page evicted on a full miss (else zero).
// Work is done by one sequencer walking the frame table and recency order one
// entry per cycle. A request for page zero changes nothing. The block takes
// one request at a time; a finished result waits in an output register while
// the next request is accepted, and a result stalls only while the previous
// one is still waiting. Writing frames_in_use (0 acts as 1, values above
// MAX_FRAMES act as MAX_FRAMES) empties all frames.

module lru_page_frame_replacer
  import lpfr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_W-1:0]       cfg_frames_in_use_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [PAGE_BITS-1:0]   page_number_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic                   hit_o,
  output logic [FRAME_IDX_W-1:0] frame_index_o,
  output logic [PAGE_BITS-1:0]   evicted_page_o
);

  localparam int IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW = $clog2(MAX_FRAMES + 1);

  lpfr_state_e state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [ORDER_W-1:0]     frame_q, frame_d;
  logic [ORDER_W-1:0]     free_q, free_d;
  logic                   free_found_q, free_found_d;
  logic                   hit_q, hit_d;
  logic [PAGE_BITS-1:0]   page_q, page_d;
  logic [PAGE_BITS-1:0]   evict_q, evict_d;
  logic [CFG_W-1:0]       cfg_q, cfg_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [FRAME_IDX_W-1:0] out_frame_q, out_frame_d;
  logic [PAGE_BITS-1:0]   out_evict_q, out_evict_d;

  logic [CFG_W-1:0]     n_cfg;
  logic [CntW-1:0]      n;
  logic                 last;
  logic [CntW-1:0]      cnt_inc;
  logic                 is_free;
  logic [ORDER_W-1:0]   free_idx;

  lpfr_store_cmd_t      cmd;
  logic [IdxW-1:0]      page_raddr, page_waddr, order_raddr, order_waddr;
  logic [PAGE_BITS-1:0] page_rdata;
  logic [ORDER_W-1:0]   order_wdata, order_rdata;
  logic                 out_load;

  lpfr_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .page_raddr_i  (page_raddr),
    .page_waddr_i  (page_waddr),
    .page_wdata_i  (page_q),
    .page_rdata_o  (page_rdata),
    .order_raddr_i (order_raddr),
    .order_waddr_i (order_waddr),
    .order_wdata_i (order_wdata),
    .order_rdata_o (order_rdata)
  );

  always_comb begin
    n_cfg = cfg_q;
    if (cfg_q == '0) begin
      n_cfg = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_FRAMES)) begin
      n_cfg = CFG_W'(MAX_FRAMES);
    end
  end

  assign n        = CntW'(n_cfg);
  assign last     = (cnt_q == CntW'(n - CntW'(1)));
  assign cnt_inc  = CntW'(cnt_q + CntW'(1));
  assign is_free  = (page_rdata == '0);
  assign free_idx = free_found_q ? free_q : ORDER_W'(cnt_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    frame_d      = frame_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    hit_d        = hit_q;
    page_d       = page_q;
    evict_d      = evict_q;
    cfg_d        = cfg_q;
    cmd          = '0;
    page_raddr   = cnt_q[IdxW-1:0];
    page_waddr   = frame_q[IdxW-1:0];
    order_raddr  = cnt_q[IdxW-1:0];
    order_waddr  = cnt_q[IdxW-1:0];
    order_wdata  = frame_q;
    in_ready_o   = 1'b0;
    cfg_ready_o  = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = 1'b1;
        if (cfg_valid_i) begin
          cfg_d     = cfg_frames_in_use_i;
          cmd.clear = 1'b1;
        end
        if (in_valid_i) begin
          page_d       = page_number_i;
          hit_d        = 1'b0;
          frame_d      = '0;
          evict_d      = '0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          state_d      = (page_number_i == '0) ? ST_RESULT : ST_SCAN;
        end
      end

      // One pass looks for the page and remembers the lowest empty frame.
      ST_SCAN: begin
        if (page_rdata == page_q) begin
          hit_d   = 1'b1;
          frame_d = ORDER_W'(cnt_q);
          cnt_d   = '0;
          state_d = ST_POS;
        end else begin
          if (is_free && !free_found_q) begin
            free_found_d = 1'b1;
            free_d       = ORDER_W'(cnt_q);
          end
          if (last) begin
            cnt_d = '0;
            if (free_found_q || is_free) begin
              frame_d     = free_idx;
              page_waddr  = free_idx[IdxW-1:0];
              cmd.page_we = 1'b1;
              state_d     = ST_SHIFT;
            end else begin
              state_d = ST_VICTIM;
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end

      // Find the hit frame in the recency order; if absent, treat it as the
      // most recent position.
      ST_POS: begin
        if (order_rdata == frame_q || last) begin
          state_d = ST_SHIFT;
        end else begin
          cnt_d = cnt_inc;
        end
      end

      ST_VICTIM: begin
        order_raddr = '0;
        if (order_rdata >= ORDER_W'(n)) begin
          frame_d = '0;
        end else begin
          frame_d = order_rdata;
        end
        state_d = ST_EVICT;
      end

      ST_EVICT: begin
        page_raddr  = frame_q[IdxW-1:0];
        evict_d     = page_rdata;
        cmd.page_we = 1'b1;
        cnt_d       = '0;
        state_d     = ST_SHIFT;
      end

      // Close the gap left at the removed position, then append the frame.
      ST_SHIFT: begin
        cmd.order_we = 1'b1;
        if (last) begin
          order_wdata = frame_q;
          state_d     = ST_RESULT;
        end else begin
          order_raddr = cnt_inc[IdxW-1:0];
          order_wdata = order_rdata;
          cnt_d       = cnt_inc;
        end
      end

      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_hit_d   = out_hit_q;
    out_frame_d = out_frame_q;
    out_evict_d = out_evict_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_hit_d   = hit_q;
      out_frame_d = frame_q[FRAME_IDX_W-1:0];
      out_evict_d = evict_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      free_found_q <= 1'b0;
      cfg_q        <= FRAMES_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      free_found_q <= free_found_d;
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q     <= frame_d;
    free_q      <= free_d;
    hit_q       <= hit_d;
    page_q      <= page_d;
    evict_q     <= evict_d;
    out_hit_q   <= out_hit_d;
    out_frame_q <= out_frame_d;
    out_evict_q <= out_evict_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign frame_index_o  = out_frame_q;
  assign evicted_page_o = out_evict_q;

endmodule

`default_nettype wire

// ----- src/lpfr_checker.sv -----
// Port-level assertions for the LRU page-frame replacer, bound to its top level.
// Depends on lpfr_pkg and lru_page_frame_replacer.
`default_nettype none

module lpfr_checker
  import lpfr_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   cfg_ready_o,
  input wire                   in_valid_i,
  input wire                   in_ready_o,
  input wire                   out_valid_o,
  input wire                   out_ready_i,
  input wire                   hit_o,
  input wire [FRAME_IDX_W-1:0] frame_index_o,
  input wire [PAGE_BITS-1:0]   evicted_page_o
);

  // A request occupies the sequencer, so the next cycle takes no new request.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while a previous one is in progress");

  // The frame count cannot change while a request is being worked on.
  a_no_cfg_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !cfg_ready_o)
    else $error("configuration port open during a request");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (evicted_page_o == '0))
    else $error("hit result reports an evicted page");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(frame_index_o) && $stable(evicted_page_o)))
    else $error("result changed or dropped before it was taken");

endmodule

bind lru_page_frame_replacer lpfr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lpfr_checker (.*);

`default_nettype wire
